// ----- rtl/hhsp_pkg.sv -----
// ---------------------------------------------------------------------------
// hhsp_pkg
// Shared types, character codes and reset values of the header stream parser
// ---------------------------------------------------------------------------
package hhsp_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [2:0] WORD_MAX = 3'd7;

	typedef enum logic [3:0] {
		PH_START   = 4'b0001,
		PH_HEADERS = 4'b0010,
		PH_BODY    = 4'b0100,
		PH_STOP    = 4'b1000
	} phase_t;

	typedef enum logic [6:0] {
		LP_BEGIN      = 7'b0000001,
		LP_NAME       = 7'b0000010,
		LP_SEP        = 7'b0000100,
		LP_VALUE      = 7'b0001000,
		LP_FOLD       = 7'b0010000,
		LP_CR         = 7'b0100000,
		LP_CR_NOCOLON = 7'b1000000
	} line_pos_t;

	typedef enum logic [2:0] {
		CLS_START    = 3'd0,
		CLS_NAME     = 3'd1,
		CLS_SEP      = 3'd2,
		CLS_VALUE    = 3'd3,
		CLS_FOLDED   = 3'd4,
		CLS_TERM     = 3'd5,
		CLS_BODY     = 3'd6,
		CLS_UNPARSED = 3'd7
	} byte_class_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_EMPTY      = 3'd1,
		ERR_NO_WORDS   = 3'd2,
		ERR_WORD_COUNT = 3'd3,
		ERR_LONE_CR    = 3'd4,
		ERR_EARLY_FOLD = 3'd5,
		ERR_NO_COLON   = 3'd6,
		ERR_TRUNCATED  = 3'd7
	} err_t;

	typedef struct packed {
		phase_t    phase;
		line_pos_t line_position;
		logic [2:0] word_count;
		logic      inside_word;
		logic      header_seen;
		logic      line_has_bytes;
		err_t      sticky_error;
	} parse_state_t;

	typedef struct packed {
		byte_class_t byte_class;
		logic        header_start;
		logic        headers_done;
		logic        simple_request;
	} tag_t;

	localparam parse_state_t PARSE_RESET = '{
		phase:          PH_START,
		line_position:  LP_BEGIN,
		word_count:     3'd0,
		inside_word:    1'b0,
		header_seen:    1'b0,
		line_has_bytes: 1'b0,
		sticky_error:   ERR_NONE
	};

endpackage

// ----- rtl/hhsp_in_if.sv -----
// ---------------------------------------------------------------------------
// hhsp_in_if
// Byte channel into the header stream parser
// ---------------------------------------------------------------------------
interface hhsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       message_start;
	logic       end_of_data;

	modport source (output valid, output data_byte, output message_start,
		output end_of_data, input ready);
	modport sink (input valid, input data_byte, input message_start,
		input end_of_data, output ready);
endinterface

// ----- rtl/hhsp_out_if.sv -----
// ---------------------------------------------------------------------------
// hhsp_out_if
// Tagged byte channel out of the header stream parser
// ---------------------------------------------------------------------------
interface hhsp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic [2:0] byte_class;
	logic       header_start;
	logic       headers_done;
	logic       simple_request;
	logic [2:0] error_code;

	modport source (output valid, output byte_out, output byte_class,
		output header_start, output headers_done, output simple_request,
		output error_code, input ready);
	modport sink (input valid, input byte_out, input byte_class,
		input header_start, input headers_done, input simple_request,
		input error_code, output ready);
endinterface

// ----- rtl/hhsp_cfg_if.sv -----
// ---------------------------------------------------------------------------
// hhsp_cfg_if
// Register write channel carrying the message kind
// ---------------------------------------------------------------------------
interface hhsp_cfg_if;
	logic valid;
	logic ready;
	logic message_kind;

	modport source (output valid, output message_kind, input ready);
	modport sink (input valid, input message_kind, output ready);
endinterface

// ----- rtl/http_header_stream_parser_unit.sv -----
// ---------------------------------------------------------------------------
// http_header_stream_parser_unit
// Tags each byte of an HTTP message with its role in the message header
// ---------------------------------------------------------------------------
// in_ch takes one message byte per item with message_start and end_of_data;
// out_ch returns one tagged item per byte, in order: the byte, its class,
// header start / headers done / simple request flags and the sticky error.
// cfg writes message_kind (0 request, 1 response); it is always ready. The
// user must write message_kind only while no item is in flight; the block
// itself does not enforce it. An input register feeds the per-byte tag
// logic, whose result and the parser state are registered together into the
// result register that drives out_ch. One item per cycle is sustained while
// out_ch does not stall, since the state update of one byte is combinational
// logic between the input register and the result register.
// When out_ch stalls the result register holds its item and the input
// register takes one more item before in_ch.ready drops.
// arst_n clears the item valid flags, the parser state and message_kind.
// ---------------------------------------------------------------------------
module http_header_stream_parser_unit
	import hhsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	hhsp_in_if.sink   in_ch,
	hhsp_out_if.source out_ch,
	hhsp_cfg_if.sink  cfg
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         start_s1;
	logic         eod_s1;
	logic         kind_q;
	parse_state_t state_q;
	parse_state_t state_nxt;
	tag_t         tag_nxt;
	logic         out_valid_q;
	logic [7:0]   byte_q;
	tag_t         tag_q;
	err_t         err_q;
	logic         advance;
	logic         in_accept;

	assign advance   = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_accept = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;

	hhsp_step u_step (
		.cur           (state_q),
		.message_kind  (kind_q),
		.data_byte     (byte_s1),
		.message_start (start_s1),
		.end_of_data   (eod_s1),
		.nxt           (state_nxt),
		.tag           (tag_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= 1'b0;
			state_q     <= PARSE_RESET;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				kind_q <= cfg.message_kind;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1  <= in_ch.data_byte;
			start_s1 <= in_ch.message_start;
			eod_s1   <= in_ch.end_of_data;
		end
		if (advance) begin
			byte_q <= byte_s1;
			tag_q  <= tag_nxt;
			err_q  <= state_nxt.sticky_error;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.byte_out       = byte_q;
	assign out_ch.byte_class     = tag_q.byte_class;
	assign out_ch.header_start   = tag_q.header_start;
	assign out_ch.headers_done   = tag_q.headers_done;
	assign out_ch.simple_request = tag_q.simple_request;
	assign out_ch.error_code     = err_q;

endmodule

// ----- rtl/hhsp_step.sv -----
// ---------------------------------------------------------------------------
// hhsp_step
// Per-byte next state and tag logic of the header stream parser
// ---------------------------------------------------------------------------
module hhsp_step
	import hhsp_pkg::*;
(
	input  parse_state_t cur,
	input  logic         message_kind,
	input  logic [7:0]   data_byte,
	input  logic         message_start,
	input  logic         end_of_data,
	output parse_state_t nxt,
	output tag_t         tag
);

	parse_state_t st;
	logic         fin;
	logic         no_colon;

	always_comb begin
		st             = message_start ? PARSE_RESET : cur;
		tag            = '{byte_class: CLS_UNPARSED, header_start: 1'b0,
		                   headers_done: 1'b0, simple_request: 1'b0};
		fin            = 1'b0;
		no_colon       = 1'b0;
		case (st.phase)
			PH_BODY: begin
				tag.byte_class = CLS_BODY;
			end
			PH_START, PH_HEADERS: begin
				if (st.line_position == LP_CR || st.line_position == LP_CR_NOCOLON) begin
					if (data_byte == CH_LF) begin
						tag.byte_class = CLS_TERM;
						fin            = 1'b1;
						no_colon       = (st.line_position == LP_CR_NOCOLON);
					end else begin
						tag.byte_class  = CLS_UNPARSED;
						st.sticky_error = ERR_LONE_CR;
						st.phase        = PH_STOP;
					end
				end else if (data_byte == CH_CR) begin
					tag.byte_class   = CLS_TERM;
					st.line_position = (st.phase == PH_HEADERS && st.line_position == LP_NAME)
					                   ? LP_CR_NOCOLON : LP_CR;
				end else if (data_byte == CH_LF) begin
					tag.byte_class = CLS_TERM;
					fin            = 1'b1;
					no_colon       = (st.phase == PH_HEADERS && st.line_position == LP_NAME);
				end else if (st.phase == PH_START) begin
					tag.byte_class    = CLS_START;
					st.line_has_bytes = 1'b1;
					if (data_byte == CH_SPACE) begin
						st.inside_word = 1'b0;
					end else if (!st.inside_word) begin
						st.inside_word = 1'b1;
						if (st.word_count != WORD_MAX) begin
							st.word_count = st.word_count + 3'd1;
						end
					end
				end else begin
					// header line bytes
					case (st.line_position)
						LP_BEGIN: begin
							st.line_has_bytes = 1'b1;
							if (data_byte == CH_SPACE) begin
								tag.byte_class   = CLS_FOLDED;
								st.line_position = LP_FOLD;
								if (!st.header_seen) begin
									st.sticky_error = ERR_EARLY_FOLD;
									st.phase        = PH_STOP;
								end
							end else begin
								tag.header_start = 1'b1;
								if (data_byte == CH_COLON) begin
									tag.byte_class   = CLS_SEP;
									st.line_position = LP_SEP;
									st.header_seen   = 1'b1;
								end else begin
									tag.byte_class   = CLS_NAME;
									st.line_position = LP_NAME;
								end
							end
						end
						LP_NAME: begin
							if (data_byte == CH_COLON) begin
								tag.byte_class   = CLS_SEP;
								st.line_position = LP_SEP;
								st.header_seen   = 1'b1;
							end else begin
								tag.byte_class = CLS_NAME;
							end
						end
						LP_SEP: begin
							if (data_byte == CH_SPACE) begin
								tag.byte_class = CLS_SEP;
							end else begin
								tag.byte_class   = CLS_VALUE;
								st.line_position = LP_VALUE;
							end
						end
						LP_VALUE: begin
							tag.byte_class = CLS_VALUE;
						end
						default: begin
							tag.byte_class = CLS_FOLDED;
						end
					endcase
				end

				// line end
				if (fin) begin
					if (st.phase == PH_START) begin
						if (!st.line_has_bytes) begin
							st.sticky_error = ERR_EMPTY;
							st.phase        = PH_STOP;
						end else if (!message_kind) begin
							if (st.word_count == 3'd0) begin
								st.sticky_error = ERR_NO_WORDS;
								st.phase        = PH_STOP;
							end else if (st.word_count == 3'd2) begin
								tag.simple_request = 1'b1;
								st.phase           = PH_STOP;
							end else if (st.word_count != 3'd3) begin
								st.sticky_error = ERR_WORD_COUNT;
								st.phase        = PH_STOP;
							end else begin
								st.phase = PH_HEADERS;
							end
						end else begin
							st.phase = PH_HEADERS;
						end
					end else if (no_colon) begin
						st.sticky_error = ERR_NO_COLON;
						st.phase        = PH_STOP;
					end else if (!st.line_has_bytes) begin
						tag.headers_done = 1'b1;
						st.phase         = PH_BODY;
					end
					st.line_position  = LP_BEGIN;
					st.line_has_bytes = 1'b0;
					st.word_count     = 3'd0;
					st.inside_word    = 1'b0;
				end

				if (end_of_data && (st.phase == PH_START || st.phase == PH_HEADERS)) begin
					st.sticky_error = ERR_TRUNCATED;
					st.phase        = PH_STOP;
				end
			end
			default: begin
				tag.byte_class = CLS_UNPARSED;
			end
		endcase
		nxt = st;
	end

endmodule

// ----- rtl/hhsp_checker.sv -----
// ---------------------------------------------------------------------------
// hhsp_checker
// Port-level checks of the header stream parser output channel
// ---------------------------------------------------------------------------
module hhsp_checker
	import hhsp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] byte_out,
	input logic [2:0] byte_class,
	input logic       header_start,
	input logic       headers_done,
	input logic       simple_request,
	input logic [2:0] error_code
);

	// a stalled item stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(byte_class)
		&& $stable(error_code))
		else $error("output item changed while stalled");

	// line end flags only on a clean lf terminator
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (headers_done || simple_request) |->
		byte_out == CH_LF && byte_class == CLS_TERM && error_code == ERR_NONE
		&& !(headers_done && simple_request))
		else $error("line end flag on wrong byte");

	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_class == CLS_TERM |-> byte_out == CH_CR || byte_out == CH_LF)
		else $error("terminator class on non line end byte");

	a_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_class == CLS_BODY |-> error_code == ERR_NONE)
		else $error("body byte carries an error");

	a_hdr_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_start |->
		(byte_class == CLS_NAME || byte_class == CLS_SEP) && byte_out != CH_SPACE)
		else $error("header start on wrong byte");

endmodule

bind http_header_stream_parser_unit hhsp_checker u_hhsp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.byte_out       (out_ch.byte_out),
	.byte_class     (out_ch.byte_class),
	.header_start   (out_ch.header_start),
	.headers_done   (out_ch.headers_done),
	.simple_request (out_ch.simple_request),
	.error_code     (out_ch.error_code)
);
